// ----- rtl/pcc_pkg.sv -----
// Shared types and constants for the path crossing collision check.
package pcc_pkg;

  localparam int WORD_BITS = 32;
  localparam int TAG_BITS  = 16;
  localparam int IDX_BITS  = 3;

  typedef enum logic [IDX_BITS-1:0] {
    REG_ROBOT_POS_X = 3'd0,
    REG_ROBOT_POS_Y = 3'd1,
    REG_ROBOT_VEL_X = 3'd2,
    REG_ROBOT_VEL_Y = 3'd3,
    REG_ROBOT_LEN   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic        [TAG_BITS-1:0]  vehicle_tag;
    logic signed [WORD_BITS-1:0] veh_pos_x;
    logic signed [WORD_BITS-1:0] veh_pos_y;
    logic signed [WORD_BITS-1:0] veh_vel_x;
    logic signed [WORD_BITS-1:0] veh_vel_y;
    logic        [WORD_BITS-2:0] veh_len;
  } in_item_t;

  typedef struct packed {
    logic        [TAG_BITS-1:0]  result_tag;
    logic signed [WORD_BITS-1:0] speed_meet_front;
    logic signed [WORD_BITS-1:0] speed_meet_back;
    logic                        will_collide;
    logic                        degenerate;
    logic                        saturated;
  } out_item_t;

endpackage

// ----- rtl/path_crossing_collision_check.sv -----
// Top level of the path crossing collision check pipeline.
// Usage:
//   Write the robot position, velocity and length through the cfg_* port
//   while no item is in flight; each write takes effect on the next edge.
//   Vehicle items enter on in_valid/in_ready, one per cycle while the receiver takes results.
//   Each item yields exactly one result item on out_valid/out_ready, in order.
// Pipeline: the bit-per-stage square root and the bit-per-stage dividers,
//   plus two stages that sum the split wide products.
// Throughput: one item per cycle while the receiver takes results.
// Reset: rst clears every stage valid bit and the robot registers to zero;
//   items in flight are dropped.
// Stall: when a result waits with out_ready low the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated, and the pipeline resumes
//   on the cycle that out_ready returns.
module path_crossing_collision_check
  import pcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [WORD_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item
);

  localparam int W   = WORD_BITS;
  localparam int DXW = W + 1;
  localparam int PW  = 2 * W;
  localparam int DW  = 2 * W + 1;
  localparam int AW  = 2 * W + 2;
  localparam int RW  = W + 3;
  localparam int TW  = 3 * W + 4;
  localparam int VW  = 4 * W + 4;
  localparam int CW  = (TW + 2) / 3;
  localparam int PPW = CW + W;

  typedef struct packed {
    logic        [TAG_BITS-1:0] tag;
    logic        [W-2:0]        len;
    logic signed [DW-1:0]       d;
    logic signed [AW-1:0]       a;
    logic signed [AW-1:0]       b;
  } ctx_t;

  typedef struct packed {
    logic [PW-1:0] rad;
    logic [RW-1:0] rem;
    logic [W-1:0]  root;
  } sq_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic                dz;
    logic                ahead;
    logic                col;
    logic                ovf_f;
    logic                ovf_b;
    logic [VW-1:0]       rf;
    logic [VW-1:0]       rb;
    logic [VW-1:0]       df;
    logic [VW-1:0]       db;
    logic [W-1:0]        quf;
    logic [W-1:0]        qub;
  } dv_t;

  function automatic sq_t sq_step(sq_t s);
    logic [RW-1:0] tmp;
    logic [RW-1:0] trial;
    sq_t r;
    tmp   = {s.rem[RW-3:0], s.rad[PW-1:PW-2]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[PW-3:0], 2'b00};
    if (tmp >= trial) begin
      r.rem  = tmp - trial;
      r.root = {s.root[W-2:0], 1'b1};
    end else begin
      r.rem  = tmp;
      r.root = {s.root[W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t dv_step(dv_t s, int i);
    logic [VW-1:0] sf;
    logic [VW-1:0] sb;
    dv_t r;
    r  = s;
    sf = s.df << i;
    sb = s.db << i;
    if (s.rf >= sf) begin
      r.rf     = s.rf - sf;
      r.quf[i] = 1'b1;
    end
    if (s.rb >= sb) begin
      r.rb     = s.rb - sb;
      r.qub[i] = 1'b1;
    end
    return r;
  endfunction

  logic signed [W-1:0] robot_pos_x, robot_pos_y, robot_vel_x, robot_vel_y;
  logic        [W-2:0] robot_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      robot_pos_x <= '0;
      robot_pos_y <= '0;
      robot_vel_x <= '0;
      robot_vel_y <= '0;
      robot_len   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROBOT_POS_X: robot_pos_x <= cfg_data;
        REG_ROBOT_POS_Y: robot_pos_y <= cfg_data;
        REG_ROBOT_VEL_X: robot_vel_x <= cfg_data;
        REG_ROBOT_VEL_Y: robot_vel_y <= cfg_data;
        REG_ROBOT_LEN:   robot_len   <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: offsets and velocity products
  logic                       s1_vld;
  logic        [TAG_BITS-1:0] s1_tag;
  logic        [W-2:0]        s1_len;
  logic signed [DXW-1:0]      s1_dx, s1_dy;
  logic signed [W-1:0]        s1_vx, s1_vy;
  logic signed [PW-1:0]       s1_p1, s1_p2;
  logic        [PW-1:0]       s1_vv;

  logic signed [DXW-1:0] c1_dx, c1_dy;
  logic signed [PW-1:0]  c1_p1, c1_p2, c1_q1, c1_q2;
  logic signed [PW:0]    c1_vv;

  always_comb begin
    c1_dx = DXW'(in_item.veh_pos_x) - DXW'(robot_pos_x);
    c1_dy = DXW'(in_item.veh_pos_y) - DXW'(robot_pos_y);
    c1_p1 = in_item.veh_vel_x * robot_vel_y;
    c1_p2 = in_item.veh_vel_y * robot_vel_x;
    c1_q1 = in_item.veh_vel_x * in_item.veh_vel_x;
    c1_q2 = in_item.veh_vel_y * in_item.veh_vel_y;
    c1_vv = (PW+1)'(c1_q1) + (PW+1)'(c1_q2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag <= in_item.vehicle_tag;
      s1_len <= in_item.veh_len;
      s1_dx  <= c1_dx;
      s1_dy  <= c1_dy;
      s1_vx  <= in_item.veh_vel_x;
      s1_vy  <= in_item.veh_vel_y;
      s1_p1  <= c1_p1;
      s1_p2  <= c1_p2;
      s1_vv  <= c1_vv[PW-1:0];
    end
  end

  // stage 2: cross product terms
  logic                       s2_vld;
  logic        [TAG_BITS-1:0] s2_tag;
  logic        [W-2:0]        s2_len;
  logic signed [DW-1:0]       s2_d;
  logic signed [DW-1:0]       s2_a1, s2_a2, s2_b1, s2_b2;
  logic        [PW-1:0]       s2_vv, s2_uu;

  logic signed [DW-1:0] c2_a1, c2_a2, c2_b1, c2_b2;
  logic signed [PW-1:0] c2_r1, c2_r2;
  logic signed [PW:0]   c2_uu;

  always_comb begin
    c2_a1 = s1_vx * s1_dy;
    c2_a2 = s1_vy * s1_dx;
    c2_b1 = robot_vel_x * s1_dy;
    c2_b2 = robot_vel_y * s1_dx;
    c2_r1 = robot_vel_x * robot_vel_x;
    c2_r2 = robot_vel_y * robot_vel_y;
    c2_uu = (PW+1)'(c2_r1) + (PW+1)'(c2_r2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tag <= s1_tag;
      s2_len <= s1_len;
      s2_d   <= DW'(s1_p1) - DW'(s1_p2);
      s2_a1  <= c2_a1;
      s2_a2  <= c2_a2;
      s2_b1  <= c2_b1;
      s2_b2  <= c2_b2;
      s2_vv  <= s1_vv;
      s2_uu  <= c2_uu[PW-1:0];
    end
  end

  // stage 3 onward: square roots, one root bit per stage
  logic sq_vld [0:W];
  sq_t  sqv    [0:W];
  sq_t  squ    [0:W];
  ctx_t sctx   [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (adv) begin
      sq_vld[0] <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqv[0]      <= '{rad: s2_vv, rem: '0, root: '0};
      squ[0]      <= '{rad: s2_uu, rem: '0, root: '0};
      sctx[0].tag <= s2_tag;
      sctx[0].len <= s2_len;
      sctx[0].d   <= s2_d;
      sctx[0].a   <= AW'(s2_a1) - AW'(s2_a2);
      sctx[0].b   <= AW'(s2_b1) - AW'(s2_b2);
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_sq
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k] <= 1'b0;
      end else if (adv) begin
        sq_vld[k] <= sq_vld[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sqv[k]  <= sq_step(sqv[k-1]);
        squ[k]  <= sq_step(squ[k-1]);
        sctx[k] <= sctx[k-1];
      end
    end
  end

  // scaled distance partial products: split the wide operand at bit W
  logic                       se_vld;
  logic        [TAG_BITS-1:0] se_tag;
  logic                       se_dz, se_ahead;
  logic        [W-1:0]        se_sv, se_su;
  logic signed [AW:0]         se_ah, se_bh;
  logic signed [DW-1:0]       se_lh, se_mh;
  logic        [PW-1:0]       se_al, se_bl, se_ll, se_ml;

  ctx_t                 ce;
  logic        [W-1:0]  ce_sv, ce_su;
  logic signed [AW:0]   ce_ah, ce_bh;
  logic signed [DW-1:0] ce_lh, ce_mh;
  logic        [PW-1:0] ce_al, ce_bl, ce_ll, ce_ml;

  always_comb begin
    ce    = sctx[W];
    ce_sv = sqv[W].root;
    ce_su = squ[W].root;
    ce_ah = (AW+1)'($signed(ce.a[AW-1:W])) * (AW+1)'($signed({1'b0, ce_su}));
    ce_al = PW'(ce.a[W-1:0]) * PW'(ce_su);
    ce_bh = (AW+1)'($signed(ce.b[AW-1:W])) * (AW+1)'($signed({1'b0, ce_sv}));
    ce_bl = PW'(ce.b[W-1:0]) * PW'(ce_sv);
    ce_lh = DW'($signed({1'b0, robot_len})) * DW'($signed(ce.d[DW-1:W]));
    ce_ll = PW'(robot_len) * PW'(ce.d[W-1:0]);
    ce_mh = DW'($signed({1'b0, ce.len})) * DW'($signed(ce.d[DW-1:W]));
    ce_ml = PW'(ce.len) * PW'(ce.d[W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      se_vld <= 1'b0;
    end else if (adv) begin
      se_vld <= sq_vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      se_tag   <= ce.tag;
      se_dz    <= (ce.d == '0);
      se_ahead <= (ce.a == '0) || (ce.a[AW-1] == ce.d[DW-1]);
      se_sv    <= ce_sv;
      se_su    <= ce_su;
      se_ah    <= ce_ah;
      se_al    <= ce_al;
      se_bh    <= ce_bh;
      se_bl    <= ce_bl;
      se_lh    <= ce_lh;
      se_ll    <= ce_ll;
      se_mh    <= ce_mh;
      se_ml    <= ce_ml;
    end
  end

  // scaled distance products
  logic                       sh_vld;
  logic        [TAG_BITS-1:0] sh_tag;
  logic                       sh_dz, sh_ahead;
  logic        [W-1:0]        sh_sv, sh_su;
  logic signed [TW-1:0]       sh_t1, sh_t2, sh_t3, sh_t4;

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_vld <= 1'b0;
    end else if (adv) begin
      sh_vld <= se_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sh_tag   <= se_tag;
      sh_dz    <= se_dz;
      sh_ahead <= se_ahead;
      sh_sv    <= se_sv;
      sh_su    <= se_su;
      sh_t1    <= (TW'(se_ah) << (W + 1)) + (TW'(se_al) << 1);
      sh_t2    <= (TW'(se_lh) << W) + TW'(se_ll);
      sh_t3    <= (TW'(se_bh) << (W + 1)) + (TW'(se_bl) << 1);
      sh_t4    <= (TW'(se_mh) << W) + TW'(se_ml);
    end
  end

  // magnitudes
  logic                       sf_vld;
  logic        [TAG_BITS-1:0] sf_tag;
  logic                       sf_dz, sf_ahead;
  logic        [W-1:0]        sf_sv, sf_su;
  logic        [TW-1:0]       sf_n, sf_qf, sf_qb;

  logic signed [TW-1:0] cf_n, cf_qf, cf_qb;

  always_comb begin
    cf_n  = sh_t1 - sh_t2;
    cf_qf = sh_t3 - sh_t4;
    cf_qb = sh_t3 + sh_t4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sf_vld <= 1'b0;
    end else if (adv) begin
      sf_vld <= sh_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sf_tag   <= sh_tag;
      sf_dz    <= sh_dz;
      sf_ahead <= sh_ahead;
      sf_sv    <= sh_sv;
      sf_su    <= sh_su;
      sf_n     <= cf_n[TW-1] ? TW'(-cf_n) : TW'(cf_n);
      sf_qf    <= cf_qf[TW-1] ? TW'(-cf_qf) : TW'(cf_qf);
      sf_qb    <= cf_qb[TW-1] ? TW'(-cf_qb) : TW'(cf_qb);
    end
  end

  // speed partial products, three chunks per operand
  logic                       sp_vld;
  logic        [TAG_BITS-1:0] sp_tag;
  logic                       sp_dz, sp_ahead;
  logic        [TW-1:0]       sp_qf, sp_qb;
  logic        [PPW-1:0]      sp_ns [0:2];
  logic        [PPW-1:0]      sp_cf [0:2];
  logic        [PPW-1:0]      sp_cb [0:2];

  logic [3*CW-1:0] cp_n, cp_qf, cp_qb;

  always_comb begin
    cp_n  = (3*CW)'(sf_n);
    cp_qf = (3*CW)'(sf_qf);
    cp_qb = (3*CW)'(sf_qb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp_vld <= 1'b0;
    end else if (adv) begin
      sp_vld <= sf_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_tag   <= sf_tag;
      sp_dz    <= sf_dz;
      sp_ahead <= sf_ahead;
      sp_qf    <= sf_qf;
      sp_qb    <= sf_qb;
      for (int j = 0; j < 3; j++) begin
        sp_ns[j] <= PPW'(cp_n[j*CW +: CW]) * PPW'(sf_sv);
        sp_cf[j] <= PPW'(cp_qf[j*CW +: CW]) * PPW'(sf_su);
        sp_cb[j] <= PPW'(cp_qb[j*CW +: CW]) * PPW'(sf_su);
      end
    end
  end

  // speed products
  logic                       sg_vld;
  logic        [TAG_BITS-1:0] sg_tag;
  logic                       sg_dz, sg_ahead;
  logic        [VW-1:0]       sg_ns, sg_cf, sg_cb, sg_qf, sg_qb;

  always_ff @(posedge clk) begin
    if (rst) begin
      sg_vld <= 1'b0;
    end else if (adv) begin
      sg_vld <= sp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sg_tag   <= sp_tag;
      sg_dz    <= sp_dz;
      sg_ahead <= sp_ahead;
      sg_ns    <= VW'(sp_ns[0]) + (VW'(sp_ns[1]) << CW) + (VW'(sp_ns[2]) << (2 * CW));
      sg_cf    <= VW'(sp_cf[0]) + (VW'(sp_cf[1]) << CW) + (VW'(sp_cf[2]) << (2 * CW));
      sg_cb    <= VW'(sp_cb[0]) + (VW'(sp_cb[1]) << CW) + (VW'(sp_cb[2]) << (2 * CW));
      sg_qf    <= VW'(sp_qf);
      sg_qb    <= VW'(sp_qb);
    end
  end

  // dividers, one quotient bit per stage
  logic dv_vld [0:W];
  dv_t  dv     [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= sg_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].tag   <= sg_tag;
      dv[0].dz    <= sg_dz;
      dv[0].ahead <= sg_ahead;
      dv[0].col   <= sg_ahead && (sg_cf <= sg_ns) && (sg_ns <= sg_cb);
      dv[0].ovf_f <= sg_ns >= (sg_qf << W);
      dv[0].ovf_b <= sg_ns >= (sg_qb << W);
      dv[0].rf    <= sg_ns;
      dv[0].rb    <= sg_ns;
      dv[0].df    <= sg_qf;
      dv[0].db    <= sg_qb;
      dv[0].quf   <= '0;
      dv[0].qub   <= '0;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_dv
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k] <= 1'b0;
      end else if (adv) begin
        dv_vld[k] <= dv_vld[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k] <= dv_step(dv[k-1], W - k);
      end
    end
  end

  // clip, sign and register the result item
  localparam logic [W-1:0] LIM_AHEAD  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_BEHIND = {1'b1, {(W-1){1'b0}}};

  dv_t        co;
  logic [W-1:0] co_lim, co_mf, co_mb;
  logic         co_sf, co_sb;
  out_item_t    co_item;

  always_comb begin
    co     = dv[W];
    co_lim = co.ahead ? LIM_AHEAD : LIM_BEHIND;
    co_sf  = co.ovf_f || (co.quf > co_lim);
    co_sb  = co.ovf_b || (co.qub > co_lim);
    co_mf  = co_sf ? co_lim : co.quf;
    co_mb  = co_sb ? co_lim : co.qub;
    co_item.result_tag = co.tag;
    if (co.dz) begin
      co_item.speed_meet_front = '0;
      co_item.speed_meet_back  = '0;
      co_item.will_collide     = 1'b0;
      co_item.degenerate       = 1'b1;
      co_item.saturated        = 1'b0;
    end else begin
      co_item.speed_meet_front = co.ahead ? co_mf : -co_mf;
      co_item.speed_meet_back  = co.ahead ? co_mb : -co_mb;
      co_item.will_collide     = co.col;
      co_item.degenerate       = 1'b0;
      co_item.saturated        = co_sf || co_sb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= co_item;
    end
  end

  a_degenerate_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.degenerate |->
      !out_item.will_collide && !out_item.saturated &&
      out_item.speed_meet_front == '0 && out_item.speed_meet_back == '0)
    else $error("degenerate result carries speeds or flags");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(dv_vld[W]) && $stable(s1_vld))
    else $error("pipeline moved during stall");

endmodule

// ----- tb/pcc_crossing_checker.sv -----
// Checker for the path crossing collision check: predicts each result and compares.
`timescale 1ns / 1ps
module pcc_crossing_checker
  import pcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [WORD_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_item,
  output int                   fail_count,
  output int                   pending
);

  typedef logic [191:0] wide_u_t;
  typedef logic signed [191:0] wide_s_t;

  logic signed [WORD_BITS-1:0] rob_px, rob_py, rob_vx, rob_vy;
  logic [WORD_BITS-2:0]        rob_len;
  out_item_t                   crossing_q[$];

  assign pending = crossing_q.size();

  function automatic wide_u_t root_floor(wide_u_t v);
    wide_u_t r, c;
    r = '0;
    for (int i = 40; i >= 0; i--) begin
      c = r | (wide_u_t'(1) << i);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] meet_speed(wide_u_t num, wide_u_t den,
                                                      logic ahead, inout logic sat);
    wide_u_t lim, m;
    lim = ahead ? ((wide_u_t'(1) << (WORD_BITS - 1)) - 1) : (wide_u_t'(1) << (WORD_BITS - 1));
    if (den == 0) begin
      m = lim;
      sat = 1'b1;
    end else begin
      m = num / den;
      if (m > lim) begin
        m = lim;
        sat = 1'b1;
      end
    end
    if (!ahead) m = -m;
    return m[WORD_BITS-1:0];
  endfunction

  function automatic out_item_t predict_crossing(in_item_t it);
    wide_s_t vx, vy, ux, uy, d, dx, dy, a, b, ns_s, tbs, ld, qf_s, qb_s;
    wide_u_t vl, rl, sv, su, n, qf, qb, ns;
    logic ahead, sat;
    out_item_t r;
    r = '0;
    r.result_tag = it.vehicle_tag;
    vx = $signed(it.veh_vel_x);
    vy = $signed(it.veh_vel_y);
    ux = $signed(rob_vx);
    uy = $signed(rob_vy);
    vl = it.veh_len;
    rl = rob_len;
    d = vx * uy - vy * ux;
    if (d == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    dx = wide_s_t'($signed(it.veh_pos_x)) - wide_s_t'($signed(rob_px));
    dy = wide_s_t'($signed(it.veh_pos_y)) - wide_s_t'($signed(rob_py));
    a = vx * dy - vy * dx;
    b = ux * dy - uy * dx;
    sv = root_floor(vx * vx + vy * vy);
    su = root_floor(ux * ux + uy * uy);
    ns_s = 2 * a * $signed(su) - $signed(rl) * d;
    n = ns_s[191] ? -ns_s : ns_s;
    ld = $signed(vl) * d;
    tbs = 2 * b * $signed(sv);
    qf_s = tbs - ld;
    qb_s = tbs + ld;
    qf = qf_s[191] ? -qf_s : qf_s;
    qb = qb_s[191] ? -qb_s : qb_s;
    ahead = (a == 0) || (a[191] == d[191]);
    ns = n * sv;
    sat = 1'b0;
    r.speed_meet_front = meet_speed(ns, qf, ahead, sat);
    r.speed_meet_back = meet_speed(ns, qb, ahead, sat);
    r.will_collide = ahead && (qf * su <= ns) && (ns <= qb * su);
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_BITS-1:0] got,
                                 logic [WORD_BITS-1:0] want, logic [TAG_BITS-1:0] tag);
    $display("mismatch tag %0h %s: got %0h want %0h", tag, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      rob_px <= '0;
      rob_py <= '0;
      rob_vx <= '0;
      rob_vy <= '0;
      rob_len <= '0;
      crossing_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (reg_idx_t'(cfg_index))
          REG_ROBOT_POS_X: rob_px <= cfg_data;
          REG_ROBOT_POS_Y: rob_py <= cfg_data;
          REG_ROBOT_VEL_X: rob_vx <= cfg_data;
          REG_ROBOT_VEL_Y: rob_vy <= cfg_data;
          REG_ROBOT_LEN:   rob_len <= cfg_data[WORD_BITS-2:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        crossing_q.insert(crossing_q.size(), predict_crossing(in_item));
      if (out_valid && out_ready) begin
        if (crossing_q.size() == 0) begin
          $display("unexpected result item tag %0h", out_item.result_tag);
          fail_count++;
        end else begin
          want = crossing_q.pop_front();
          if (out_item.result_tag !== want.result_tag)
            report_mismatch("result_tag", WORD_BITS'(out_item.result_tag),
                            WORD_BITS'(want.result_tag), want.result_tag);
          if (out_item.speed_meet_front !== want.speed_meet_front)
            report_mismatch("speed_meet_front", out_item.speed_meet_front,
                            want.speed_meet_front, want.result_tag);
          if (out_item.speed_meet_back !== want.speed_meet_back)
            report_mismatch("speed_meet_back", out_item.speed_meet_back,
                            want.speed_meet_back, want.result_tag);
          if (out_item.will_collide !== want.will_collide)
            report_mismatch("will_collide", WORD_BITS'(out_item.will_collide),
                            WORD_BITS'(want.will_collide), want.result_tag);
          if (out_item.degenerate !== want.degenerate)
            report_mismatch("degenerate", WORD_BITS'(out_item.degenerate),
                            WORD_BITS'(want.degenerate), want.result_tag);
          if (out_item.saturated !== want.saturated)
            report_mismatch("saturated", WORD_BITS'(out_item.saturated),
                            WORD_BITS'(want.saturated), want.result_tag);
        end
      end
    end
  end

endmodule

// ----- tb/path_crossing_collision_check_tb.sv -----
// Top of the path crossing collision check testbench: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module path_crossing_collision_check_tb;
  import pcc_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 2 * WORD_BITS + 30;
  localparam logic [WORD_BITS-1:0] MAX_S = 32'h7fff_ffff;
  localparam logic [WORD_BITS-1:0] MIN_S = 32'h8000_0000;

  logic                 clk, rst;
  logic                 cfg_wr_en;
  logic [IDX_BITS-1:0]  cfg_index;
  logic [WORD_BITS-1:0] cfg_data;
  logic                 in_valid, in_ready, out_valid, out_ready;
  in_item_t             in_item;
  out_item_t            out_item;
  int                   fail_count, pending, idle_cycles;
  logic [TAG_BITS-1:0]  next_tag;

  path_crossing_collision_check DUT (.*);

  pcc_crossing_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [WORD_BITS-1:0] meters(int lo, int hi);
    return (WORD_BITS'($signed($urandom_range(hi - lo) + lo)) << 16) + $urandom_range(65535);
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [WORD_BITS-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic set_robot(logic [WORD_BITS-1:0] px, py, vx, vy, logic [WORD_BITS-2:0] len);
    write_reg(REG_ROBOT_POS_X, px);
    write_reg(REG_ROBOT_POS_Y, py);
    write_reg(REG_ROBOT_VEL_X, vx);
    write_reg(REG_ROBOT_VEL_Y, vy);
    write_reg(REG_ROBOT_LEN, {1'b0, len});
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_vehicle(logic [WORD_BITS-1:0] px, py, vx, vy, logic [WORD_BITS-2:0] len,
                              bit gaps);
    in_item_t it;
    int gap;
    it.vehicle_tag = next_tag;
    it.veh_pos_x = px;
    it.veh_pos_y = py;
    it.veh_vel_x = vx;
    it.veh_vel_y = vy;
    it.veh_len = len;
    next_tag = next_tag + 1;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_vehicle(logic [WORD_BITS-1:0] rvx, rvy);
    int p, k;
    p = $urandom_range(99);
    if (p < 60) begin
      send_vehicle(meters(-80, 80), meters(-80, 80), meters(-20, 20), meters(-20, 20),
                   (WORD_BITS-1)'(meters(0, 12)), 1'b1);
    end else if (p < 70) begin
      k = $urandom_range(3) - 1;
      send_vehicle(meters(-80, 80), meters(-80, 80), rvx * k, rvy * k,
                   (WORD_BITS-1)'(meters(0, 12)), 1'b1);
    end else begin
      send_vehicle($urandom, $urandom, $urandom, $urandom, (WORD_BITS-1)'($urandom), 1'b1);
    end
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      out_ready <= ($urandom_range(99) < 65);
      repeat (($urandom_range(99) < 8) ? $urandom_range(10, 60) : $urandom_range(1, 4))
        @(posedge clk);
    end
  end

  initial begin
    logic [WORD_BITS-1:0] rvx, rvy;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_item <= '0;
    next_tag = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // robot at rest after reset: every vehicle is degenerate
    send_vehicle(32'h0001_0000, 0, 32'h0001_0000, 0, 31'h0002_0000, 1'b0);
    drain_and_settle();

    // robot moving along +x at 1 m/s, 2 m long
    set_robot(0, 0, 32'h0001_0000, 0, 31'h0002_0000);
    send_vehicle(32'h000a_0000, 32'hfff6_0000, 0, 32'h0001_0000, 31'h0004_0000, 1'b0);
    send_vehicle(32'h000a_0000, 32'hfffb_0000, 0, 32'h0001_0000, 31'h0004_0000, 1'b0);
    send_vehicle(32'hfff6_0000, 32'hfff6_0000, 0, 32'h0001_0000, 31'h0004_0000, 1'b0);
    send_vehicle(32'h000a_0000, 32'h000a_0000, 0, 32'hffff_0000, 31'h0004_0000, 1'b0);
    send_vehicle(32'h0005_0000, 32'h0005_0000, 32'h0002_0000, 0, 31'h0001_0000, 1'b0);
    send_vehicle(32'h0005_0000, 32'h0005_0000, 0, 0, 31'h0001_0000, 1'b0);
    send_vehicle(0, 32'hfffe_0000, 0, 32'h0001_0000, 31'h0004_0000, 1'b0);
    send_vehicle(32'h0001_0000, 0, 0, 32'h0001_0000, 31'h0000_0000, 1'b0);
    send_vehicle(MAX_S, MIN_S, MAX_S, MIN_S, 31'h7fff_ffff, 1'b0);
    send_vehicle(MIN_S, MAX_S, MIN_S, MAX_S, 31'h0, 1'b0);
    send_vehicle(MAX_S, MAX_S, 1, MAX_S, 31'h7fff_ffff, 1'b0);
    send_vehicle(MIN_S, MIN_S, 0, MIN_S, 31'h7fff_ffff, 1'b0);
    send_vehicle(32'h0003_0000, 32'hfffd_0000, 32'h0001_0000, 32'h0001_0000,
                 31'h0002_0000, 1'b0);
    send_vehicle(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 31'h1, 1'b0);
    drain_and_settle();

    // extreme robot settings, a fixed one, then random ones
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_robot(MAX_S, MAX_S, MAX_S, MAX_S, 31'h7fff_ffff);
        1: set_robot(MIN_S, MIN_S, MIN_S, MIN_S, 31'h0);
        2: set_robot(0, 0, 0, 32'h0003_0000, 31'h0001_8000);
        3: set_robot($urandom, $urandom, $urandom, $urandom, (WORD_BITS-1)'($urandom));
        default: set_robot(meters(-30, 30), meters(-30, 30), meters(-5, 5), meters(-5, 5),
                           (WORD_BITS-1)'(meters(0, 5)));
      endcase
      rvx = (phase == 0) ? MAX_S : (phase == 1) ? MIN_S : (phase == 2) ? 32'h0 : $urandom;
      rvy = (phase == 0) ? MAX_S : (phase == 1) ? MIN_S : (phase == 2) ? 32'h0003_0000 : $urandom;
      if (phase >= 4) begin
        rvx = 32'h0001_0000;
        rvy = 32'h0001_0000;
      end
      repeat (phase < 4 ? 50 : 100) random_vehicle(rvx, rvy);
      drain_and_settle();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pcc_pkg.sv
rtl/path_crossing_collision_check.sv
tb/pcc_crossing_checker.sv
tb/path_crossing_collision_check_tb.sv
